// ----- rtl/assert_macros.svh -----
// assertion macros shared by the rtl
// no dependencies
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// property must hold at every clock edge outside reset
`define ASSERT_CLK(label, prop, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (prop)) else $error(msg);

// condition must never be seen outside reset
`define ASSERT_NEVER(label, cond, msg) \
  label: assert property (@(posedge clk) disable iff (rst) !(cond)) else $error(msg);

`endif

// ----- rtl/pcc_pkg.sv -----
// types, constants and term set tables for the polynomial colour correction
// no dependencies
package pcc_pkg;

  localparam int TERM_COUNT    = 35;
  localparam int MAX_TERMS_DEF = 35;
  localparam int CH_W          = 16;
  localparam int TERM_W        = 17;
  localparam int COEF_W        = 24;
  localparam int ACC_W         = 48;
  localparam int MODE_W        = 4;
  localparam int POS_W         = 6;

  localparam logic [TERM_W-1:0] ONE_Q16  = TERM_W'(65536);
  localparam logic [POS_W-1:0]  NO_TERM  = 6'd63;
  localparam logic [MODE_W-1:0] MODE_MAX = 4'd13;

  typedef struct packed {
    logic                     valid;
    logic                     pix;   // 1 pixel, 0 coefficient write
    logic                     wen;   // write lands inside the store
    logic [POS_W-1:0]         wpos;
    logic [1:0]               wch;
    logic signed [COEF_W-1:0] wval;
  } ctl_t;

  typedef logic [TERM_COUNT-1:0][TERM_W-1:0] term_vec_t;
  typedef logic [2:0][ACC_W-1:0] acc_vec_t;

  function automatic logic [POS_W-1:0] set_len(input logic [MODE_W-1:0] mode);
    logic [POS_W-1:0] n;
    unique case (mode)
      4'd0:    n = 6'd3;
      4'd1:    n = 6'd4;
      4'd2:    n = 6'd5;
      4'd3:    n = 6'd7;
      4'd4:    n = 6'd8;
      4'd5:    n = 6'd10;
      4'd6:    n = 6'd11;
      4'd7:    n = 6'd14;
      4'd8:    n = 6'd16;
      4'd9:    n = 6'd17;
      4'd10:   n = 6'd19;
      4'd11:   n = 6'd20;
      4'd12:   n = 6'd22;
      default: n = 6'd35;
    endcase
    return n;
  endfunction

  // term index used at a position of the chosen set, NO_TERM past its end
  function automatic logic [POS_W-1:0] set_term(input logic [MODE_W-1:0] mode,
                                                input logic [POS_W-1:0]  pos);
    logic [MODE_W-1:0] m;
    logic [POS_W-1:0]  pre;
    logic [POS_W-1:0]  j;
    logic [POS_W-1:0]  k;
    m = (mode > MODE_MAX) ? MODE_MAX : mode;
    unique case (m)
      4'd0, 4'd1, 4'd2: pre = 6'd3;
      4'd3, 4'd4:       pre = 6'd6;
      4'd5:             pre = 6'd9;
      4'd6, 4'd7:       pre = 6'd10;
      4'd8, 4'd9:       pre = 6'd13;
      4'd10, 4'd11, 4'd12: pre = 6'd19;
      default:          pre = 6'd35;
    endcase
    j = pos - pre;
    if (pos >= set_len(m)) begin
      k = NO_TERM;
    end else if (pos < pre) begin
      k = pos;
    end else begin
      unique case (m)
        4'd2, 4'd4:       k = (j == 6'd0) ? 6'd9 : 6'd34;
        4'd7, 4'd8, 4'd9: k = (j < 6'd3) ? 6'd16 + j : 6'd34;
        4'd12:            k = 6'd25 + j;
        default:          k = 6'd34;
      endcase
    end
    return k;
  endfunction

endpackage

// ----- rtl/pcc_expand.sv -----
// three stage product expansion of one pixel into the full term vector
// depends on pcc_pkg
module pcc_expand (
  input  logic                            clk,
  input  logic                            rst,
  input  logic                            en,
  input  pcc_pkg::ctl_t                   ctl_in,
  input  logic [pcc_pkg::CH_W-1:0]        red,
  input  logic [pcc_pkg::CH_W-1:0]        green,
  input  logic [pcc_pkg::CH_W-1:0]        blue,
  output pcc_pkg::ctl_t                   ctl_out,
  output pcc_pkg::term_vec_t              terms
);
  import pcc_pkg::*;

  typedef logic [CH_W-1:0] ch_t;

  // product truncated back to q0.16
  function automatic ch_t mulq(input ch_t a, input ch_t b);
    logic [2*CH_W-1:0] p;
    p = a * b;
    return p[2*CH_W-1:CH_W];
  endfunction

  ctl_t ctl1, ctl2;
  ch_t s1_r, s1_g, s1_b, s1_rg, s1_rb, s1_gb, s1_r2, s1_g2, s1_b2;
  ch_t s2_r, s2_g, s2_b, s2_rg, s2_rb, s2_gb, s2_r2, s2_g2, s2_b2;
  ch_t s2_r3, s2_g3, s2_b3, s2_rgb, s2_r2g, s2_g2b, s2_rb2, s2_r2b, s2_rg2, s2_gb2;
  ch_t s2_r2g2, s2_r2b2, s2_g2b2, s2_r4, s2_g4, s2_b4;

  always_ff @(posedge clk) begin
    if (rst) begin
      ctl1    <= '0;
      ctl2    <= '0;
      ctl_out <= '0;
    end else if (en) begin
      ctl1    <= ctl_in;
      ctl2    <= ctl1;
      ctl_out <= ctl2;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      s1_r  <= red;
      s1_g  <= green;
      s1_b  <= blue;
      s1_rg <= mulq(red, green);
      s1_rb <= mulq(red, blue);
      s1_gb <= mulq(green, blue);
      s1_r2 <= mulq(red, red);
      s1_g2 <= mulq(green, green);
      s1_b2 <= mulq(blue, blue);

      s2_r  <= s1_r;
      s2_g  <= s1_g;
      s2_b  <= s1_b;
      s2_rg <= s1_rg;
      s2_rb <= s1_rb;
      s2_gb <= s1_gb;
      s2_r2 <= s1_r2;
      s2_g2 <= s1_g2;
      s2_b2 <= s1_b2;
      s2_r3   <= mulq(s1_r2, s1_r);
      s2_g3   <= mulq(s1_g2, s1_g);
      s2_b3   <= mulq(s1_b2, s1_b);
      s2_rgb  <= mulq(s1_rg, s1_b);
      s2_r2g  <= mulq(s1_r2, s1_g);
      s2_g2b  <= mulq(s1_g2, s1_b);
      s2_rb2  <= mulq(s1_r, s1_b2);
      s2_r2b  <= mulq(s1_r2, s1_b);
      s2_rg2  <= mulq(s1_r, s1_g2);
      s2_gb2  <= mulq(s1_g, s1_b2);
      s2_r2g2 <= mulq(s1_r2, s1_g2);
      s2_r2b2 <= mulq(s1_r2, s1_b2);
      s2_g2b2 <= mulq(s1_g2, s1_b2);
      s2_r4   <= mulq(s1_r2, s1_r2);
      s2_g4   <= mulq(s1_g2, s1_g2);
      s2_b4   <= mulq(s1_b2, s1_b2);

      // published term order, constant last
      terms[0]  <= {1'b0, s2_r};
      terms[1]  <= {1'b0, s2_g};
      terms[2]  <= {1'b0, s2_b};
      terms[3]  <= {1'b0, s2_rg};
      terms[4]  <= {1'b0, s2_rb};
      terms[5]  <= {1'b0, s2_gb};
      terms[6]  <= {1'b0, s2_r2};
      terms[7]  <= {1'b0, s2_g2};
      terms[8]  <= {1'b0, s2_b2};
      terms[9]  <= {1'b0, s2_rgb};
      terms[10] <= {1'b0, s2_r2g};
      terms[11] <= {1'b0, s2_g2b};
      terms[12] <= {1'b0, s2_rb2};
      terms[13] <= {1'b0, s2_r2b};
      terms[14] <= {1'b0, s2_rg2};
      terms[15] <= {1'b0, s2_gb2};
      terms[16] <= {1'b0, s2_r3};
      terms[17] <= {1'b0, s2_g3};
      terms[18] <= {1'b0, s2_b3};
      terms[19] <= {1'b0, mulq(s2_r3, s2_g)};
      terms[20] <= {1'b0, mulq(s2_r3, s2_b)};
      terms[21] <= {1'b0, mulq(s2_r, s2_g3)};
      terms[22] <= {1'b0, mulq(s2_g3, s2_b)};
      terms[23] <= {1'b0, mulq(s2_r, s2_b3)};
      terms[24] <= {1'b0, mulq(s2_g, s2_b3)};
      terms[25] <= {1'b0, mulq(s2_r2g, s2_b)};
      terms[26] <= {1'b0, mulq(s2_rg2, s2_b)};
      terms[27] <= {1'b0, mulq(s2_rg, s2_b2)};
      terms[28] <= {1'b0, s2_r2g2};
      terms[29] <= {1'b0, s2_r2b2};
      terms[30] <= {1'b0, s2_g2b2};
      terms[31] <= {1'b0, s2_r4};
      terms[32] <= {1'b0, s2_g4};
      terms[33] <= {1'b0, s2_b4};
      terms[34] <= ONE_Q16;
    end
  end

endmodule

// ----- rtl/pcc_cell.sv -----
// one chain cell: holds the three coefficients of one term position
// and adds its weighted term to the passing sums; depends on pcc_pkg
module pcc_cell #(
  parameter int N   = pcc_pkg::MAX_TERMS_DEF,
  parameter int IDX = 0
) (
  input  logic                                 clk,
  input  logic                                 rst,
  input  logic                                 en,
  input  pcc_pkg::ctl_t                        ctl_in,
  input  logic [N-1:0][pcc_pkg::TERM_W-1:0]    terms_in,
  input  pcc_pkg::acc_vec_t                    acc_in,
  output pcc_pkg::ctl_t                        ctl_out,
  output logic [N-1:0][pcc_pkg::TERM_W-1:0]    terms_out,
  output pcc_pkg::acc_vec_t                    acc_out
);
  import pcc_pkg::*;

  localparam int PROD_W = TERM_W + 1 + COEF_W;

  logic signed [COEF_W-1:0] coef [3];
  logic signed [PROD_W-1:0] prod [3];
  logic                     hit;

  assign hit = ctl_in.valid && !ctl_in.pix && ctl_in.wen &&
               (ctl_in.wpos == POS_W'(IDX));

  always_comb begin
    for (int c = 0; c < 3; c++) begin
      prod[c] = $signed({1'b0, terms_in[IDX]}) * coef[c];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      ctl_out <= '0;
    end else if (en) begin
      ctl_out <= ctl_in;
    end
  end

  // a write reaches this cell in stream order with the pixels
  always_ff @(posedge clk) begin
    if (en && hit) begin
      coef[ctl_in.wch] <= ctl_in.wval;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      terms_out <= terms_in;
      for (int c = 0; c < 3; c++) begin
        acc_out[c] <= $signed(acc_in[c]) + ACC_W'(prod[c]);
      end
    end
  end

endmodule

// ----- rtl/polynomial_color_correct.sv -----
// pipeline from input transfer to result: 3 expansion stages, term select,
// one cell per term position, output register
// throughput: one item per cycle unless res_stall holds a valid result; the whole chain advances on one enable
// reset: rst clears the valid bits and term_mode; coefficients are undefined
// until written
module polynomial_color_correct #(
  parameter int MAX_TERMS = pcc_pkg::MAX_TERMS_DEF
) (
  input  logic                                clk,
  input  logic                                rst,
  input  logic                                cfg_write,
  input  logic [pcc_pkg::MODE_W-1:0]          cfg_wdata,
  input  logic                                pix_valid,
  output logic                                pix_stall,
  input  logic                                kind,
  input  logic [6:0]                          coef_slot,
  input  logic signed [pcc_pkg::COEF_W-1:0]   coef_value,
  input  logic [pcc_pkg::CH_W-1:0]            red_in,
  input  logic [pcc_pkg::CH_W-1:0]            green_in,
  input  logic [pcc_pkg::CH_W-1:0]            blue_in,
  output logic                                res_valid,
  input  logic                                res_stall,
  output logic [pcc_pkg::CH_W-1:0]            red_out,
  output logic [pcc_pkg::CH_W-1:0]            green_out,
  output logic [pcc_pkg::CH_W-1:0]            blue_out,
  output logic                                clipped
);
  import pcc_pkg::*;
`include "assert_macros.svh"

  localparam logic [6:0] SLOT_LIMIT = 7'(MAX_TERMS * 3);

  typedef logic [MAX_TERMS-1:0][TERM_W-1:0] pos_vec_t;

  logic              en;
  logic [MODE_W-1:0] term_mode;
  ctl_t              in_ctl, exp_ctl, sel_ctl;
  term_vec_t         exp_terms;
  pos_vec_t          sel_terms;
  logic [14:0]       slot_mul;
  logic [POS_W-1:0]  slot_pos;
  logic [6:0]        slot_base;

  ctl_t      chain_ctl   [MAX_TERMS+1];
  pos_vec_t  chain_terms [MAX_TERMS+1];
  acc_vec_t  chain_acc   [MAX_TERMS+1];

  assign en        = !res_valid || !res_stall;
  assign pix_stall = !en;

  always_ff @(posedge clk) begin
    if (rst) begin
      term_mode <= '0;
    end else if (cfg_write) begin
      term_mode <= cfg_wdata;
    end
  end

  // slot / 3 by reciprocal, exact over the 7 bit range
  assign slot_mul  = 15'(coef_slot) * 15'd171;
  assign slot_pos  = slot_mul[14:9];
  assign slot_base = 7'(slot_pos) * 7'd3;

  always_comb begin
    in_ctl.valid = pix_valid;
    in_ctl.pix   = kind;
    in_ctl.wen   = (coef_slot < SLOT_LIMIT);
    in_ctl.wpos  = slot_pos;
    in_ctl.wch   = 2'(coef_slot - slot_base);
    in_ctl.wval  = coef_value;
  end

  pcc_expand u_expand (
    .clk     (clk),
    .rst     (rst),
    .en      (en),
    .ctl_in  (in_ctl),
    .red     (red_in),
    .green   (green_in),
    .blue    (blue_in),
    .ctl_out (exp_ctl),
    .terms   (exp_terms)
  );

  // pick the term of each position for the current set
  always_ff @(posedge clk) begin
    if (rst) begin
      sel_ctl <= '0;
    end else if (en) begin
      sel_ctl <= exp_ctl;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      for (int i = 0; i < MAX_TERMS; i++) begin
        logic [POS_W-1:0] k;
        k = set_term(term_mode, POS_W'(i));
        sel_terms[i] <= (k == NO_TERM) ? '0 : exp_terms[k];
      end
    end
  end

  assign chain_ctl[0]   = sel_ctl;
  assign chain_terms[0] = sel_terms;
  assign chain_acc[0]   = '0;

  for (genvar i = 0; i < MAX_TERMS; i++) begin : g_cell
    pcc_cell #(
      .N   (MAX_TERMS),
      .IDX (i)
    ) u_cell (
      .clk       (clk),
      .rst       (rst),
      .en        (en),
      .ctl_in    (chain_ctl[i]),
      .terms_in  (chain_terms[i]),
      .acc_in    (chain_acc[i]),
      .ctl_out   (chain_ctl[i+1]),
      .terms_out (chain_terms[i+1]),
      .acc_out   (chain_acc[i+1])
    );
  end

  // floor to q0.16 and clamp
  function automatic logic [CH_W:0] clamp(input logic [ACC_W-1:0] a);
    logic [CH_W:0] r;
    if (a[ACC_W-1]) begin
      r = {1'b1, {CH_W{1'b0}}};
    end else if (|a[ACC_W-2:2*CH_W]) begin
      r = {1'b1, {CH_W{1'b1}}};
    end else begin
      r = {1'b0, a[2*CH_W-1:CH_W]};
    end
    return r;
  endfunction

  logic [CH_W:0] cl_r, cl_g, cl_b;
  ctl_t          last_ctl;

  assign last_ctl = chain_ctl[MAX_TERMS];
  assign cl_r = clamp(chain_acc[MAX_TERMS][0]);
  assign cl_g = clamp(chain_acc[MAX_TERMS][1]);
  assign cl_b = clamp(chain_acc[MAX_TERMS][2]);

  always_ff @(posedge clk) begin
    if (rst) begin
      res_valid <= 1'b0;
    end else if (en) begin
      res_valid <= last_ctl.valid && last_ctl.pix;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      red_out   <= cl_r[CH_W-1:0];
      green_out <= cl_g[CH_W-1:0];
      blue_out  <= cl_b[CH_W-1:0];
      clipped   <= cl_r[CH_W] || cl_g[CH_W] || cl_b[CH_W];
    end
  end

  `ASSERT_CLK(a_write_no_result, en && last_ctl.valid && !last_ctl.pix |=> !res_valid, "coefficient write produced a result")
  `ASSERT_NEVER(a_clip_extreme, res_valid && clipped && red_out != '0 && red_out != '1 && green_out != '0 && green_out != '1 && blue_out != '0 && blue_out != '1, "clip flag without a clamped channel")
  `ASSERT_CLK(a_hold_select, !en |=> $stable(sel_ctl) && $stable(sel_terms), "select stage moved while stalled")

endmodule
